@@ rtl/core/hxy_pkg.sv @@
// Shared types and constants for the Hilbert index to x,y converter.
// No dependencies; used by every module under rtl/core.
package hxy_pkg;

  // Fixed field widths
  localparam int unsigned INDEX_W = 33;
  localparam int unsigned COORD_W = 17;
  localparam int unsigned ORDER_W = 5;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;

  // Register map: register index is paddr[2]
  localparam logic REG_IDX_GRID_ORDER = 1'b0;

  // Reset value of grid_order
  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd4;

  // Per-item control that travels down the level pipeline
  typedef struct packed {
    logic               err;
    logic [ORDER_W-1:0] order;
    logic [1:0]         orient;
    logic               rev;
  } hxy_ctl_t;

  // One result transaction
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               err;
  } hxy_res_t;

endpackage

@@ rtl/core/hxy_entry.sv @@
// Entry stage: forms the zero-based index, clamps the order and flags bad indexes.
// Depends on hxy_pkg.
module hxy_entry #(
  parameter int unsigned MAX_ORDER = 16,
  parameter int unsigned REM_W     = 33
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hxy_pkg::INDEX_W-1:0]   in_curve_index,
  input  logic [hxy_pkg::ORDER_W-1:0]   grid_order,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [REM_W-1:0]              out_rem,
  output hxy_pkg::hxy_ctl_t             out_ctl
);

  logic                         valid_r;
  logic [REM_W-1:0]             rem_r;
  logic [REM_W-1:0]             rem_nxt;
  hxy_pkg::hxy_ctl_t            ctl_r;
  hxy_pkg::hxy_ctl_t            ctl_nxt;
  logic [hxy_pkg::INDEX_W-1:0]  idx_m1;
  logic [hxy_pkg::ORDER_W-1:0]  eff_order;
  logic [hxy_pkg::ORDER_W:0]    cell_bits;
  logic                         beyond;

  assign in_ready = !valid_r || out_ready;

  // Clamp order, subtract one, check bits above 2*order
  always_comb begin
    if (grid_order > hxy_pkg::ORDER_W'(MAX_ORDER)) begin
      eff_order = hxy_pkg::ORDER_W'(MAX_ORDER);
    end else begin
      eff_order = grid_order;
    end
    cell_bits = {eff_order, 1'b0};
    idx_m1    = in_curve_index - hxy_pkg::INDEX_W'(1);
    beyond    = 1'b0;
    for (int i = 0; i < int'(hxy_pkg::INDEX_W); i++) begin
      if ((hxy_pkg::ORDER_W+1)'(i) >= cell_bits) begin
        beyond = beyond | idx_m1[i];
      end
    end
    rem_nxt        = REM_W'(idx_m1);
    ctl_nxt.err    = (in_curve_index == '0) || beyond;
    ctl_nxt.order  = eff_order;
    ctl_nxt.orient = 2'd0;
    ctl_nxt.rev    = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r <= rem_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_ctl   = ctl_r;

endmodule

@@ rtl/core/hxy_level.sv @@
// One curve level: picks the quadrant from two index bits and sets one offset bit.
// Depends on hxy_pkg.
module hxy_level #(
  parameter int unsigned LEVEL = 1,
  parameter int unsigned REM_W = 33,
  parameter int unsigned OFF_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REM_W-1:0]  in_rem,
  input  hxy_pkg::hxy_ctl_t in_ctl,
  input  logic [OFF_W-1:0]  in_xoff,
  input  logic [OFF_W-1:0]  in_yoff,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [REM_W-1:0]  out_rem,
  output hxy_pkg::hxy_ctl_t out_ctl,
  output logic [OFF_W-1:0]  out_xoff,
  output logic [OFF_W-1:0]  out_yoff
);

  logic              valid_r;
  logic [REM_W-1:0]  rem_r;
  hxy_pkg::hxy_ctl_t ctl_r;
  hxy_pkg::hxy_ctl_t ctl_nxt;
  logic [OFF_W-1:0]  xoff_r;
  logic [OFF_W-1:0]  xoff_nxt;
  logic [OFF_W-1:0]  yoff_r;
  logic [OFF_W-1:0]  yoff_nxt;
  logic [1:0]        pos;
  logic [1:0]        quad;
  logic              active;

  assign in_ready = !valid_r || out_ready;

  // Quadrant mapping and orientation update for this level
  always_comb begin
    ctl_nxt  = in_ctl;
    xoff_nxt = in_xoff;
    yoff_nxt = in_yoff;
    active   = in_ctl.order >= hxy_pkg::ORDER_W'(LEVEL);
    pos      = in_rem[2*LEVEL-1 -: 2];
    if (in_ctl.rev) begin
      quad = in_ctl.orient - pos;
    end else begin
      quad = in_ctl.orient + pos;
    end
    if (active) begin
      yoff_nxt[LEVEL-1] = (quad == 2'd1) || (quad == 2'd2);
      xoff_nxt[LEVEL-1] = (quad == 2'd2) || (quad == 2'd3);
      if (pos == 2'd0) begin
        ctl_nxt.rev = !in_ctl.rev;
      end
      if (pos == 2'd3) begin
        ctl_nxt.rev    = !in_ctl.rev;
        ctl_nxt.orient = in_ctl.orient + 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r  <= in_rem;
      ctl_r  <= ctl_nxt;
      xoff_r <= xoff_nxt;
      yoff_r <= yoff_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_ctl   = ctl_r;
  assign out_xoff  = xoff_r;
  assign out_yoff  = yoff_r;

endmodule

@@ rtl/core/hxy_out.sv @@
// Output stage: turns offsets into 1-based coordinates, two-entry skid buffer.
// Depends on hxy_pkg.
module hxy_out #(
  parameter int unsigned OFF_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hxy_pkg::hxy_ctl_t in_ctl,
  input  logic [OFF_W-1:0]  in_xoff,
  input  logic [OFF_W-1:0]  in_yoff,
  output logic              out_valid,
  input  logic              out_ready,
  output hxy_pkg::hxy_res_t out_res
);

  localparam int unsigned SUM_W = (OFF_W + 1 > hxy_pkg::COORD_W) ?
                                  OFF_W + 1 : hxy_pkg::COORD_W;

  logic              out_valid_r;
  logic              skid_valid_r;
  hxy_pkg::hxy_res_t out_r;
  hxy_pkg::hxy_res_t skid_r;
  hxy_pkg::hxy_res_t res_nxt;
  logic [SUM_W-1:0]  x_sum;
  logic [SUM_W-1:0]  y_sum;
  logic              load_out;

  // Add one, force zero on error
  always_comb begin
    x_sum       = SUM_W'(in_xoff) + SUM_W'(1);
    y_sum       = SUM_W'(in_yoff) + SUM_W'(1);
    res_nxt.err = in_ctl.err;
    if (in_ctl.err) begin
      res_nxt.x = '0;
      res_nxt.y = '0;
    end else begin
      res_nxt.x = x_sum[hxy_pkg::COORD_W-1:0];
      res_nxt.y = y_sum[hxy_pkg::COORD_W-1:0];
    end
  end

  assign in_ready = !skid_valid_r;
  assign load_out = out_ready || !out_valid_r;

  // Valid bits of output and skid entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r  <= skid_valid_r || in_valid;
      skid_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload moves
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_valid) begin
        out_r <= res_nxt;
      end
    end else if (in_valid && in_ready) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

@@ rtl/core/hilbert_index_to_xy_unit.sv @@
// Hilbert curve index to 1-based x,y converter: top level with config register.
// Depends on hxy_pkg, hxy_entry, hxy_level, hxy_out.
// Pipeline from input accept to out_valid: one entry stage, one stage per curve level,
// one output register.
// Throughput: one transaction per cycle while out_ready is high; a two-entry output buffer absorbs a stall.
// Reset (rst_n low, synchronous) empties the pipeline and sets grid_order to 4.
module hilbert_index_to_xy_unit #(
  parameter int unsigned MAX_ORDER = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hxy_pkg::INDEX_W-1:0]   in_curve_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hxy_pkg::COORD_W-1:0]   out_x_coord,
  output logic [hxy_pkg::COORD_W-1:0]   out_y_coord,
  output logic                          out_index_error,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hxy_pkg::APB_AW-1:0]    paddr,
  input  logic [hxy_pkg::APB_DW-1:0]    pwdata,
  output logic [hxy_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned REM_W = (2 * MAX_ORDER > hxy_pkg::INDEX_W) ?
                                  2 * MAX_ORDER : hxy_pkg::INDEX_W;
  localparam int unsigned OFF_W = MAX_ORDER;

  logic [hxy_pkg::ORDER_W-1:0] grid_order_r;
  logic                        cfg_wr;

  logic              st_valid [0:MAX_ORDER];
  logic              st_ready [0:MAX_ORDER];
  logic [REM_W-1:0]  st_rem   [0:MAX_ORDER];
  hxy_pkg::hxy_ctl_t st_ctl   [0:MAX_ORDER];
  logic [OFF_W-1:0]  st_xoff  [0:MAX_ORDER];
  logic [OFF_W-1:0]  st_yoff  [0:MAX_ORDER];
  hxy_pkg::hxy_res_t res;

  // Configuration register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_order_r <= hxy_pkg::ORDER_RESET;
    end else if (cfg_wr && (paddr[2] == hxy_pkg::REG_IDX_GRID_ORDER)) begin
      grid_order_r <= pwdata[hxy_pkg::ORDER_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      hxy_pkg::REG_IDX_GRID_ORDER: prdata = hxy_pkg::APB_DW'(grid_order_r);
      default:                     prdata = '0;
    endcase
  end

  // Entry stage
  hxy_entry #(
    .MAX_ORDER (MAX_ORDER),
    .REM_W     (REM_W)
  ) u_entry (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_curve_index (in_curve_index),
    .grid_order     (grid_order_r),
    .out_valid      (st_valid[0]),
    .out_ready      (st_ready[0]),
    .out_rem        (st_rem[0]),
    .out_ctl        (st_ctl[0])
  );

  assign st_xoff[0] = '0;
  assign st_yoff[0] = '0;

  // One stage per level, top level of the curve first
  for (genvar j = 0; j < MAX_ORDER; j++) begin : g_level
    hxy_level #(
      .LEVEL (MAX_ORDER - j),
      .REM_W (REM_W),
      .OFF_W (OFF_W)
    ) u_level (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (st_valid[j]),
      .in_ready  (st_ready[j]),
      .in_rem    (st_rem[j]),
      .in_ctl    (st_ctl[j]),
      .in_xoff   (st_xoff[j]),
      .in_yoff   (st_yoff[j]),
      .out_valid (st_valid[j+1]),
      .out_ready (st_ready[j+1]),
      .out_rem   (st_rem[j+1]),
      .out_ctl   (st_ctl[j+1]),
      .out_xoff  (st_xoff[j+1]),
      .out_yoff  (st_yoff[j+1])
    );
  end

  // Output conversion and buffering
  hxy_out #(
    .OFF_W (OFF_W)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (st_valid[MAX_ORDER]),
    .in_ready  (st_ready[MAX_ORDER]),
    .in_ctl    (st_ctl[MAX_ORDER]),
    .in_xoff   (st_xoff[MAX_ORDER]),
    .in_yoff   (st_yoff[MAX_ORDER]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_x_coord     = res.x;
  assign out_y_coord     = res.y;
  assign out_index_error = res.err;

endmodule

@@ rtl/core/hxy_checker.sv @@
// Port-level checks for hilbert_index_to_xy_unit, attached with bind.
// Depends on hxy_pkg.
module hxy_checker #(
  parameter int unsigned MAX_ORDER = 16
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [hxy_pkg::COORD_W-1:0] out_x_coord,
  input logic [hxy_pkg::COORD_W-1:0] out_y_coord,
  input logic                        out_index_error
);

  // Reset leaves no result transaction pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result transaction stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Error results carry zero coordinates
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_error |-> (out_x_coord == '0) && (out_y_coord == '0))
    else $error("error result with nonzero coordinates");

  // Good results are 1-based when coordinates fit the field
  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_index_error && (MAX_ORDER <= 16) |->
      (out_x_coord != '0) && (out_y_coord != '0))
    else $error("valid result with zero coordinate");

endmodule

bind hilbert_index_to_xy_unit hxy_checker #(
  .MAX_ORDER (MAX_ORDER)
) u_hxy_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_x_coord     (out_x_coord),
  .out_y_coord     (out_y_coord),
  .out_index_error (out_index_error)
);

@@ test/tb_top.sv @@
// Self-checking testbench for hilbert_index_to_xy_unit: curve index in, 1-based cell out.
// Depends on hxy_pkg and the RTL under rtl/core; the expected cells come from a local predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ORDER = 16;
  localparam int unsigned SETTLE_CYCLES = MAX_ORDER + 8;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [hxy_pkg::INDEX_W-1:0]  in_curve_index = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [hxy_pkg::COORD_W-1:0]  out_x_coord;
  logic [hxy_pkg::COORD_W-1:0]  out_y_coord;
  logic                         out_index_error;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [hxy_pkg::APB_AW-1:0]   paddr = '0;
  logic [hxy_pkg::APB_DW-1:0]   pwdata = '0;
  logic [hxy_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  // Indexes waiting to be sent, and cells expected back in order
  logic [hxy_pkg::INDEX_W-1:0]  index_backlog[$];
  hxy_pkg::hxy_res_t            cell_queue[$];

  logic [hxy_pkg::ORDER_W-1:0]  order_shadow = hxy_pkg::ORDER_RESET;
  int unsigned                  send_idle_pct = 0;
  int unsigned                  recv_stall_pct = 0;
  int unsigned                  fail_count = 0;
  logic                         in_taken = 1'b0;

  hilbert_index_to_xy_unit #(.MAX_ORDER(MAX_ORDER)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_curve_index(in_curve_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x_coord(out_x_coord), .out_y_coord(out_y_coord),
    .out_index_error(out_index_error),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock: 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Walks the quadrant levels from the top down and returns the cell
  function automatic hxy_pkg::hxy_res_t hilbert_cell(
      input logic [hxy_pkg::INDEX_W-1:0] idx,
      input logic [hxy_pkg::ORDER_W-1:0] order);
    int unsigned n;
    int unsigned k;
    int unsigned sh;
    logic [63:0] cells;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] x;
    logic [63:0] y;
    logic [1:0]  orient;
    logic [1:0]  pos;
    logic [1:0]  quad;
    logic        rev;
    hxy_pkg::hxy_res_t cell_res;
    n = (order > MAX_ORDER) ? MAX_ORDER : order;
    cells = 64'd1 << (2 * n);
    cell_res = '0;
    if (idx == '0 || 64'(idx) > cells) begin
      cell_res.err = 1'b1;
      return cell_res;
    end
    rem = 64'(idx) - 64'd1;
    x = 64'd1;
    y = 64'd1;
    orient = 2'd0;
    rev = 1'b0;
    for (k = n; k > 0; k--) begin
      sh = 2 * (k - 1);
      pos = 2'(rem >> sh);
      half = 64'd1 << (k - 1);
      quad = rev ? (orient - pos) : (orient + pos);
      if (quad == 2'd1 || quad == 2'd2) y += half;
      if (quad == 2'd2 || quad == 2'd3) x += half;
      // first quadrant flips direction; last also turns the frame by two
      if (pos == 2'd0) rev = ~rev;
      if (pos == 2'd3) begin
        rev = ~rev;
        orient = orient + 2'd2;
      end
    end
    cell_res.x = x[hxy_pkg::COORD_W-1:0];
    cell_res.y = y[hxy_pkg::COORD_W-1:0];
    return cell_res;
  endfunction

  // Random index: mostly on the grid, some zero, boundary and wide values
  function automatic logic [hxy_pkg::INDEX_W-1:0] random_curve_index(
      input logic [hxy_pkg::ORDER_W-1:0] order);
    int unsigned n;
    int unsigned pick;
    logic [63:0] cells;
    logic [63:0] raw;
    n = (order > MAX_ORDER) ? MAX_ORDER : order;
    cells = 64'd1 << (2 * n);
    raw = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 4) return '0;
    if (pick < 12) return raw[hxy_pkg::INDEX_W-1:0];
    if (pick < 16) return hxy_pkg::INDEX_W'(cells + 64'($urandom_range(1)));
    return hxy_pkg::INDEX_W'((raw & (cells - 64'd1)) + 64'd1);
  endfunction

  // Driver: new transaction at the falling edge once the previous one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (index_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_curve_index <= index_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
          in_curve_index <= hxy_pkg::INDEX_W'({$urandom, $urandom});
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    hxy_pkg::hxy_res_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready)
        cell_queue = {cell_queue, hilbert_cell(in_curve_index, order_shadow)};
      if (out_valid && out_ready) begin
        if (cell_queue.size() == 0) begin
          $error("unexpected result transaction x=%0d y=%0d err=%0b",
                 out_x_coord, out_y_coord, out_index_error);
          fail_count++;
        end else begin
          want = cell_queue.pop_front();
          if (out_x_coord !== want.x) begin
            $error("x_coord expected %0d actual %0d", want.x, out_x_coord);
            fail_count++;
          end
          if (out_y_coord !== want.y) begin
            $error("y_coord expected %0d actual %0d", want.y, out_y_coord);
            fail_count++;
          end
          if (out_index_error !== want.err) begin
            $error("index_error expected %0b actual %0b", want.err, out_index_error);
            fail_count++;
          end
        end
      end
    end
  end

  // Block until nothing is queued, in flight or outstanding
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (index_backlog.size() != 0 || in_valid || cell_queue.size() != 0);
  endtask

  // Append one index to the send backlog
  task automatic enqueue_index(input logic [hxy_pkg::INDEX_W-1:0] idx);
    index_backlog = {index_backlog, idx};
  endtask

  // APB write: setup then access, completes on pready
  task automatic write_grid_order(input logic [hxy_pkg::ORDER_W-1:0] order);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {hxy_pkg::REG_IDX_GRID_ORDER, 2'b00};
    pwdata = hxy_pkg::APB_DW'(order);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    order_shadow = order;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    pwdata = '0;
  endtask

  // One random phase at a fixed order and idle mix
  task automatic run_phase(input logic [hxy_pkg::ORDER_W-1:0] order,
                           input int unsigned send_pct,
                           input int unsigned recv_pct, input int unsigned count,
                           input bit pause_mid);
    wait_drained();
    write_grid_order(order);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int unsigned i = 0; i < count; i++) begin
      // hold the sender until the pipeline has emptied
      if (pause_mid && i == count / 2) wait_drained();
      enqueue_index(random_curve_index(order));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset order 4, zero, first, last and past-the-end indexes
    enqueue_index(33'd0);
    enqueue_index(33'd1);
    enqueue_index(33'd2);
    enqueue_index(33'd256);
    enqueue_index(33'd257);
    enqueue_index('1);
    wait_drained();
    // Single-cell grid
    write_grid_order(5'd0);
    enqueue_index(33'd0);
    enqueue_index(33'd1);
    enqueue_index(33'd2);
    wait_drained();
    // Two by two grid walks all four quadrants
    write_grid_order(5'd1);
    for (int unsigned i = 1; i <= 5; i++) enqueue_index(33'(i));
    wait_drained();
    // Largest grid: edges of the index range
    write_grid_order(5'd16);
    enqueue_index(33'd1);
    enqueue_index(33'h0_FFFF_FFFF);
    enqueue_index(33'h1_0000_0000);
    enqueue_index(33'h1_0000_0001);
    enqueue_index('1);
    wait_drained();
    // Order above the maximum saturates
    write_grid_order(5'd31);
    enqueue_index(33'h1_0000_0000);
    enqueue_index(33'h1_0000_0001);
    enqueue_index(33'h0_AAAA_AAAB);

    // Random phases over orders and idle mixes
    run_phase(5'd16, 0, 0, 72, 1'b1);
    run_phase(5'd2, 70, 0, 72, 1'b0);
    run_phase(5'd7, 0, 70, 72, 1'b0);
    run_phase(5'd0, 7, 7, 72, 1'b0);
    run_phase(5'd31, 0, 0, 72, 1'b0);
    run_phase(5'd11, 70, 0, 72, 1'b0);
    run_phase(5'd1, 0, 70, 72, 1'b0);
    run_phase(5'd17, 7, 7, 72, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/hxy_pkg.sv
rtl/core/hxy_entry.sv
rtl/core/hxy_level.sv
rtl/core/hxy_out.sv
rtl/core/hilbert_index_to_xy_unit.sv
rtl/core/hxy_checker.sv
test/tb_top.sv
